[rtl/core/packbits_planar_image_unpacker_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the PackBits planar image unpacker
// Each macro expects signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef PACKBITS_PLANAR_IMAGE_UNPACKER_CORE_MACROS_SVH
`define PACKBITS_PLANAR_IMAGE_UNPACKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pbu_pkg.sv]
// ----------------------------------------------------------------------------
// PackBits unpacker package
// Field widths, codes, screen geometry tables and the address stepping function.
// ----------------------------------------------------------------------------
package pbu_pkg;

    localparam int VALUE_W = 8;
    localparam int ADDR_W  = 15;
    localparam int COUNT_W = 2;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;
    localparam int ROW_W   = 9;
    localparam int PLANE_W = 2;
    localparam int BIR_W   = 8;
    localparam int NP_W    = 3;

    // Run parser phases.
    localparam logic [1:0] PHASE_PREFIX  = 2'd0;
    localparam logic [1:0] PHASE_LITERAL = 2'd1;
    localparam logic [1:0] PHASE_REPEAT  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DONE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVERRUN = 2'd2;

    // Commands from the controller to the datapath.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_ITEM  = 2'd1;
    localparam logic [1:0] CMD_LATCH = 2'd2;
    localparam logic [1:0] CMD_PAIR  = 2'd3;

    // Resolution modes.
    localparam logic [MODE_W-1:0] MODE_4PLANE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_2PLANE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_1PLANE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET  = MODE_1PLANE;

    localparam logic [7:0] LITERAL_MAX = 8'd127;
    localparam logic [7:0] REPEAT_MIN  = 8'd129;
    localparam logic [8:0] REPEAT_BASE = 9'd257;

    localparam int ROW_BYTES_M0 = (320 / 8) * 4;
    localparam int ROW_BYTES_M1 = (640 / 8) * 2;
    localparam int ROW_BYTES_M2 = (640 / 8) * 1;
    localparam int ROWS_M0 = 200;
    localparam int ROWS_M1 = 200;
    localparam int ROWS_M2 = 400;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [PLANE_W-1:0] plane_index;
        logic [BIR_W-1:0]   byte_in_row;
        logic [ADDR_W-1:0]  row_base;
    } pos_t;

    typedef struct packed {
        logic [1:0] op;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic rep_pending;
        logic pair_last;
    } dp_status_t;

    function automatic logic [NP_W-1:0] pbu_planes(input logic [MODE_W-1:0] m);
        logic [NP_W-1:0] r;
        case (m)
            MODE_4PLANE: r = 3'd4;
            MODE_2PLANE: r = 3'd2;
            default:     r = 3'd1;
        endcase
        return r;
    endfunction

    function automatic logic [BIR_W-1:0] pbu_row_bytes(input logic [MODE_W-1:0] m);
        logic [BIR_W-1:0] r;
        case (m)
            MODE_4PLANE: r = BIR_W'(ROW_BYTES_M0);
            MODE_2PLANE: r = BIR_W'(ROW_BYTES_M1);
            default:     r = BIR_W'(ROW_BYTES_M2);
        endcase
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] pbu_rows(input logic [MODE_W-1:0] m);
        logic [ROW_W-1:0] r;
        case (m)
            MODE_4PLANE: r = ROW_W'(ROWS_M0);
            MODE_2PLANE: r = ROW_W'(ROWS_M1);
            default:     r = ROW_W'(ROWS_M2);
        endcase
        return r;
    endfunction

    // Position after one byte: word pairs per plane, then next plane, then next row.
    function automatic pos_t pbu_advance(input pos_t p, input logic [MODE_W-1:0] m);
        pos_t             r;
        logic [NP_W-1:0]  np;
        logic [BIR_W-1:0] bpr;
        logic [BIR_W:0]   bir;
        logic [NP_W-1:0]  pl;
        np  = pbu_planes(m);
        bpr = pbu_row_bytes(m);
        r   = p;
        bir = {1'b0, p.byte_in_row} + 9'd1;
        if (!bir[0])
        begin
            bir = bir + {5'd0, np, 1'b0} - 9'd2;
            if (bir >= {1'b0, bpr})
            begin
                pl = {1'b0, p.plane_index} + 3'd1;
                if (pl >= np)
                begin
                    pl          = 3'd0;
                    r.row_base  = p.row_base + {7'd0, bpr};
                    r.row_index = p.row_index + 9'd1;
                end
                r.plane_index = pl[PLANE_W-1:0];
                bir           = {5'd0, pl, 1'b0};
            end
        end
        r.byte_in_row = bir[BIR_W-1:0];
        return r;
    endfunction

endpackage

[rtl/core/pbu_if.sv]
// ----------------------------------------------------------------------------
// PackBits unpacker channels
// Input byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface pbu_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [pbu_pkg::VALUE_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink (input valid, input func, input value, output ready);
endinterface

interface pbu_out_if;
    logic                        valid;
    logic                        ready;
    logic [pbu_pkg::COUNT_W-1:0] write_count;
    logic [pbu_pkg::ADDR_W-1:0]  addr_a;
    logic [pbu_pkg::VALUE_W-1:0] byte_a;
    logic [pbu_pkg::ADDR_W-1:0]  addr_b;
    logic [pbu_pkg::VALUE_W-1:0] byte_b;
    logic                        last;
    logic [pbu_pkg::STAT_W-1:0]  status;

    modport source (output valid, output write_count, output addr_a, output byte_a,
                    output addr_b, output byte_b, output last, output status, input ready);
    modport sink (input valid, input write_count, input addr_a, input byte_a,
                  input addr_b, input byte_b, input last, input status, output ready);
endinterface

interface pbu_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [pbu_pkg::MODE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/core/pbu_ctrl.sv]
// ----------------------------------------------------------------------------
// PackBits unpacker controller
// Takes items when the result register is free and sequences repeat runs.
// ----------------------------------------------------------------------------
module pbu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_func,
    output logic                in_ready,
    input  logic                out_ready,
    input  pbu_pkg::dp_status_t status,
    output pbu_pkg::cmd_t       cmd
);
    import pbu_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_PAIR = 1'b1;

    logic state_reg;
    logic state_next;
    logic slot_free;

    assign slot_free = !status.out_busy || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;

    always_comb
    begin
        cmd.op     = CMD_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && slot_free)
                begin
                    // A data byte of a repeat run is latched, then drained in pairs.
                    if (!in_func && status.rep_pending)
                    begin
                        cmd.op     = CMD_LATCH;
                        state_next = S_PAIR;
                    end
                    else
                    begin
                        cmd.op = CMD_ITEM;
                    end
                end
            end
            S_PAIR:
            begin
                if (slot_free)
                begin
                    cmd.op = CMD_PAIR;
                    if (status.pair_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/pbu_datapath.sv]
// ----------------------------------------------------------------------------
// PackBits unpacker datapath
// Run parser, screen position counters, address steps and result register.
// ----------------------------------------------------------------------------
`include "packbits_planar_image_unpacker_core_macros.svh"

module pbu_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pbu_pkg::cmd_t                cmd,
    output pbu_pkg::dp_status_t          status,
    input  logic                         in_func,
    input  logic [pbu_pkg::VALUE_W-1:0]  in_value,
    input  logic                         cfg_write,
    input  logic [pbu_pkg::MODE_W-1:0]   cfg_data,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [pbu_pkg::COUNT_W-1:0]  out_write_count,
    output logic [pbu_pkg::ADDR_W-1:0]   out_addr_a,
    output logic [pbu_pkg::VALUE_W-1:0]  out_byte_a,
    output logic [pbu_pkg::ADDR_W-1:0]   out_addr_b,
    output logic [pbu_pkg::VALUE_W-1:0]  out_byte_b,
    output logic                         out_last,
    output logic [pbu_pkg::STAT_W-1:0]   out_status
);
    import pbu_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [1:0]         phase_reg;
    logic [1:0]         phase_next;
    logic [7:0]         rem_reg;
    logic [7:0]         rem_next;
    pos_t               pos_reg;
    pos_t               pos_next;
    logic               ov_reg;
    logic               ov_next;
    logic [VALUE_W-1:0] rep_byte_reg;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_count_next;
    logic [ADDR_W-1:0]  out_addr_a_reg;
    logic [ADDR_W-1:0]  out_addr_a_next;
    logic [VALUE_W-1:0] out_byte_a_reg;
    logic [VALUE_W-1:0] out_byte_a_next;
    logic [ADDR_W-1:0]  out_addr_b_reg;
    logic [ADDR_W-1:0]  out_addr_b_next;
    logic [VALUE_W-1:0] out_byte_b_reg;
    logic [VALUE_W-1:0] out_byte_b_next;
    logic               out_last_reg;
    logic               out_last_next;
    logic [STAT_W-1:0]  out_status_reg;
    logic [STAT_W-1:0]  out_status_next;
    logic               out_load;

    logic [MODE_W-1:0]  mode_sel;
    logic [ROW_W-1:0]   rows;
    logic               ok_a;
    logic               ok_b;
    pos_t               pos_a;
    pos_t               pos_b;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;

    // Pair step of a repeat run.
    logic [1:0]         pair_writes;
    logic               pair_fail;
    pos_t               pair_pos;
    logic [7:0]         pair_rem;
    logic               pair_last;
    logic               pair_ov;

    logic [7:0]         lit_rem;
    logic               boundary;

    assign mode_sel = (mode_reg > MODE_1PLANE) ? MODE_1PLANE : mode_reg;
    assign rows     = pbu_rows(mode_sel);
    assign ok_a     = !ov_reg && (pos_reg.row_index < rows);
    assign pos_a    = pbu_advance(pos_reg, mode_sel);
    assign ok_b     = pos_a.row_index < rows;
    assign pos_b    = pbu_advance(pos_a, mode_sel);
    assign addr_a   = pos_reg.row_base + {7'd0, pos_reg.byte_in_row};
    assign addr_b   = pos_a.row_base + {7'd0, pos_a.byte_in_row};

    always_comb
    begin
        pair_fail   = 1'b0;
        pair_writes = 2'd0;
        pair_pos    = pos_reg;
        if (!ok_a)
        begin
            pair_fail = 1'b1;
        end
        else if (rem_reg < 8'd2)
        begin
            pair_writes = 2'd1;
            pair_pos    = pos_a;
        end
        else if (ok_b)
        begin
            pair_writes = 2'd2;
            pair_pos    = pos_b;
        end
        else
        begin
            pair_writes = 2'd1;
            pair_pos    = pos_a;
            pair_fail   = 1'b1;
        end
        pair_rem  = rem_reg - {6'd0, pair_writes};
        // End the run early when the next write would already be dropped, so
        // that no empty result trails the last pair of writes.
        pair_last = pair_fail || (pair_rem == 8'd0) || (pair_pos.row_index >= rows);
        pair_ov   = ov_reg || pair_fail || ((pair_rem != 8'd0) && (pair_pos.row_index >= rows));
    end

    assign lit_rem = (rem_reg != 8'd0) ? (rem_reg - 8'd1) : 8'd0;

    always_comb
    begin
        phase_next      = phase_reg;
        rem_next        = rem_reg;
        pos_next        = pos_reg;
        ov_next         = ov_reg;
        boundary        = 1'b0;
        out_load        = 1'b0;
        out_count_next  = 2'd0;
        out_addr_a_next = '0;
        out_byte_a_next = '0;
        out_addr_b_next = '0;
        out_byte_b_next = '0;
        out_last_next   = 1'b1;
        out_status_next = STAT_OK;
        case (cmd.op)
            CMD_ITEM:
            begin
                out_load = 1'b1;
                if (in_func)
                begin
                    phase_next = PHASE_PREFIX;
                    rem_next   = 8'd0;
                    pos_next   = '0;
                    ov_next    = 1'b0;
                end
                else
                begin
                    case (phase_reg)
                        PHASE_LITERAL:
                        begin
                            if (ok_a)
                            begin
                                pos_next        = pos_a;
                                out_count_next  = 2'd1;
                                out_addr_a_next = addr_a;
                                out_byte_a_next = in_value;
                            end
                            else
                            begin
                                ov_next = 1'b1;
                            end
                            rem_next = lit_rem;
                            if (lit_rem == 8'd0)
                            begin
                                phase_next = PHASE_PREFIX;
                                boundary   = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (in_value <= LITERAL_MAX)
                            begin
                                phase_next = PHASE_LITERAL;
                                rem_next   = in_value + 8'd1;
                            end
                            else if (in_value >= REPEAT_MIN)
                            begin
                                phase_next = PHASE_REPEAT;
                                rem_next   = 8'(REPEAT_BASE - {1'b0, in_value});
                            end
                            else
                            begin
                                phase_next = PHASE_PREFIX;
                                boundary   = 1'b1;
                            end
                        end
                    endcase
                    if (ov_next)
                    begin
                        out_status_next = STAT_OVERRUN;
                    end
                    else if (boundary && (pos_next.row_index >= rows))
                    begin
                        out_status_next = STAT_DONE;
                    end
                end
            end
            CMD_PAIR:
            begin
                out_load        = 1'b1;
                pos_next        = pair_pos;
                out_count_next  = pair_writes;
                out_last_next   = pair_last;
                if (pair_writes != 2'd0)
                begin
                    out_addr_a_next = addr_a;
                    out_byte_a_next = rep_byte_reg;
                end
                if (pair_writes == 2'd2)
                begin
                    out_addr_b_next = addr_b;
                    out_byte_b_next = rep_byte_reg;
                end
                if (pair_last)
                begin
                    phase_next = PHASE_PREFIX;
                    rem_next   = 8'd0;
                    ov_next    = pair_ov;
                    if (pair_ov)
                    begin
                        out_status_next = STAT_OVERRUN;
                    end
                    else if (pair_pos.row_index >= rows)
                    begin
                        out_status_next = STAT_DONE;
                    end
                end
                else
                begin
                    rem_next = pair_rem;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_RESET;
            phase_reg     <= PHASE_PREFIX;
            rem_reg       <= 8'd0;
            pos_reg       <= '0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= cfg_data;
            end
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_LATCH)
        begin
            rep_byte_reg <= in_value;
        end
        if (out_load)
        begin
            out_count_reg  <= out_count_next;
            out_addr_a_reg <= out_addr_a_next;
            out_byte_a_reg <= out_byte_a_next;
            out_addr_b_reg <= out_addr_b_next;
            out_byte_b_reg <= out_byte_b_next;
            out_last_reg   <= out_last_next;
            out_status_reg <= out_status_next;
        end
    end

    assign status.out_busy    = out_valid_reg;
    assign status.rep_pending = (phase_reg == PHASE_REPEAT);
    assign status.pair_last   = pair_last;

    assign out_valid       = out_valid_reg;
    assign out_write_count = out_count_reg;
    assign out_addr_a      = out_addr_a_reg;
    assign out_byte_a      = out_byte_a_reg;
    assign out_addr_b      = out_addr_b_reg;
    assign out_byte_b      = out_byte_b_reg;
    assign out_last        = out_last_reg;
    assign out_status      = out_status_reg;

    `PBU_ASSERT_NEXT(a_overrun_sticky, ov_reg && !(cmd.op == CMD_ITEM && in_func), ov_reg, "overrun cleared without a start")
    `PBU_ASSERT_NEXT(a_run_closed, (cmd.op == CMD_PAIR) && pair_last, (phase_reg == PHASE_PREFIX) && (rem_reg == 8'd0), "repeat run not closed after its last pair")
    `PBU_ASSERT_NOW(a_overrun_status, out_valid_reg && (out_status_reg == STAT_OVERRUN), ov_reg, "overrun status without overrun flag")
    `PBU_ASSERT_NOW(a_lane_b_clear, out_valid_reg && (out_count_reg != 2'd2), (out_addr_b_reg == '0) && (out_byte_b_reg == '0), "unused second lane not cleared")

endmodule

[rtl/core/packbits_planar_image_unpacker_core.sv]
// ----------------------------------------------------------------------------
// PackBits planar image unpacker
// Decodes a PackBits picture body into interleaved bitplane screen writes.
// ----------------------------------------------------------------------------
//  channel   modport   carries
//  stream    sink      func, value: one compressed byte or a start of image
//  writes    source    write_count, addr_a, byte_a, addr_b, byte_b, last, status
//  cfg       sink      data: resolution_mode, always ready
//
// A start, a prefix or a literal data byte gives one result.
// A repeat data byte of n copies is latched, then drained as one result per cycle
// while the sink takes them, the datapath stepping the address twice per result.
// Results pass through a single output register; a new item is taken when that
// register is empty or being emptied, so a stalled sink holds the input.
// Reset sets resolution_mode to 2 and clears the position and run state.
// ----------------------------------------------------------------------------
module packbits_planar_image_unpacker_core (
    input logic      clk,
    input logic      rst_n,
    pbu_in_if.sink   stream,
    pbu_out_if.source writes,
    pbu_cfg_if.sink  cfg
);
    import pbu_pkg::*;

    cmd_t       cmd;
    dp_status_t dp_status;

    assign cfg.ready = 1'b1;

    pbu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_func   (stream.func),
        .in_ready  (stream.ready),
        .out_ready (writes.ready),
        .status    (dp_status),
        .cmd       (cmd)
    );

    pbu_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (dp_status),
        .in_func         (stream.func),
        .in_value        (stream.value),
        .cfg_write       (cfg.valid),
        .cfg_data        (cfg.data),
        .out_ready       (writes.ready),
        .out_valid       (writes.valid),
        .out_write_count (writes.write_count),
        .out_addr_a      (writes.addr_a),
        .out_byte_a      (writes.byte_a),
        .out_addr_b      (writes.addr_b),
        .out_byte_b      (writes.byte_b),
        .out_last        (writes.last),
        .out_status      (writes.status)
    );

endmodule

[tb/tb_packbits_planar_image_unpacker_core.sv]
// ----------------------------------------------------------------------------
// Testbench for the PackBits planar image unpacker core
// A short stimulus table, a single-plane fill of half the screen that reaches
// the complete and overrun states after a switch to four planes, and random
// run streams under every resolution mode. Each result is compared field by
// field with the output of a behavioral decoder kept in this file, while both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_packbits_planar_image_unpacker_core;

    import pbu_pkg::*;

    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [VALUE_W-1:0] PFX_NOP    = 8'd128;
    localparam logic [MODE_W-1:0]  MODE_ALIAS = 2'd3;

    localparam int SIDE_SEND = 0;
    localparam int SIDE_RECV = 1;

    typedef struct packed {
        logic [COUNT_W-1:0] write_count;
        logic [ADDR_W-1:0]  addr_a;
        logic [VALUE_W-1:0] byte_a;
        logic [ADDR_W-1:0]  addr_b;
        logic [VALUE_W-1:0] byte_b;
        logic               last;
        logic [STAT_W-1:0]  status;
    } screen_write_t;

    typedef struct packed {
        logic               func;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [COUNT_W-1:0] write_count;
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] data;
        logic [STAT_W-1:0]  status;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pbu_in_if  stream_ch();
    pbu_out_if writes_ch();
    pbu_cfg_if cfg_ch();

    packbits_planar_image_unpacker_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .writes (writes_ch),
        .cfg    (cfg_ch)
    );

    // Decoder state, mirrored from the block's point of view.
    logic [MODE_W-1:0]  img_mode;
    logic [1:0]         parse_phase;
    logic [8:0]         run_left;
    logic [ROW_W-1:0]   cur_row;
    logic [PLANE_W-1:0] cur_plane;
    logic [BIR_W-1:0]   cur_col;
    logic [ADDR_W-1:0]  cur_base;
    logic               overrun_seen;

    logic [ADDR_W-1:0]  burst_addr[$];
    logic [VALUE_W-1:0] burst_data[$];
    screen_write_t      due_results[$];
    stim_row_t          directed_rows[$];

    int error_total;
    int items_sent;
    int results_taken;
    int quiet_left[2];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic void mode_geometry(input logic [MODE_W-1:0] m, output int planes,
                                          output int row_bytes, output int rows);
        int width;
        case (m)
            MODE_4PLANE:
            begin
                planes = 4;
                width  = 320;
                rows   = 200;
            end
            MODE_2PLANE:
            begin
                planes = 2;
                width  = 640;
                rows   = 200;
            end
            default:
            begin
                planes = 1;
                width  = 640;
                rows   = 400;
            end
        endcase
        row_bytes = (width / 8) * planes;
    endfunction

    function automatic void clear_position();
        parse_phase  = PHASE_PREFIX;
        run_left     = '0;
        cur_row      = '0;
        cur_plane    = '0;
        cur_col      = '0;
        cur_base     = '0;
        overrun_seen = 1'b0;
    endfunction

    // One screen byte: word pairs within a plane, then the next plane, then the next row.
    function automatic bit place_byte(input logic [VALUE_W-1:0] b);
        int np;
        int bpr;
        int nrows;
        int col;
        int pl;
        mode_geometry(img_mode, np, bpr, nrows);
        if (overrun_seen || int'(cur_row) >= nrows)
        begin
            overrun_seen = 1'b1;
            return 1'b0;
        end
        burst_addr.push_back(ADDR_W'(cur_base + cur_col));
        burst_data.push_back(b);
        col = int'(cur_col) + 1;
        if ((col & 1) == 0)
        begin
            col = col + 2 * np - 2;
            if (col >= bpr)
            begin
                pl = int'(cur_plane) + 1;
                if (pl >= np)
                begin
                    pl       = 0;
                    cur_base = cur_base + ADDR_W'(bpr);
                    cur_row  = cur_row + 1'b1;
                end
                cur_plane = PLANE_W'(pl);
                col       = 2 * pl;
            end
        end
        cur_col = BIR_W'(col);
        return 1'b1;
    endfunction

    function automatic void decode_byte(input logic f, input logic [VALUE_W-1:0] v);
        bit                boundary;
        logic [STAT_W-1:0] st;
        int                np;
        int                bpr;
        int                nrows;
        int                n;
        int                n_res;
        int                first;
        int                i;
        screen_write_t     r;
        boundary = 1'b0;
        burst_addr.delete();
        burst_data.delete();
        if (f == FUNC_START)
        begin
            clear_position();
        end
        else if (parse_phase == PHASE_LITERAL)
        begin
            void'(place_byte(v));
            if (run_left > 0)
                run_left = run_left - 1'b1;
            if (run_left == 0)
            begin
                parse_phase = PHASE_PREFIX;
                boundary    = 1'b1;
            end
        end
        else if (parse_phase == PHASE_REPEAT)
        begin
            // A repeat run stops at its first dropped write.
            for (i = 0; i < int'(run_left); i++)
            begin
                if (!place_byte(v))
                    break;
            end
            run_left    = '0;
            parse_phase = PHASE_PREFIX;
            boundary    = 1'b1;
        end
        else if (v <= LITERAL_MAX)
        begin
            parse_phase = PHASE_LITERAL;
            run_left    = v + 9'd1;
        end
        else if (v >= REPEAT_MIN)
        begin
            parse_phase = PHASE_REPEAT;
            run_left    = REPEAT_BASE - v;
        end
        else
        begin
            boundary = 1'b1;
        end

        mode_geometry(img_mode, np, bpr, nrows);
        if (overrun_seen)
            st = STAT_OVERRUN;
        else if (boundary && int'(cur_row) >= nrows)
            st = STAT_DONE;
        else
            st = STAT_OK;

        n     = burst_addr.size();
        n_res = (n == 0) ? 1 : (n + 1) / 2;
        for (i = 0; i < n_res; i++)
        begin
            r     = '0;
            first = 2 * i;
            if (n > first)
            begin
                r.write_count = (n - first >= 2) ? 2'd2 : 2'd1;
                r.addr_a      = burst_addr[first];
                r.byte_a      = burst_data[first];
            end
            if (n > first + 1)
            begin
                r.addr_b = burst_addr[first + 1];
                r.byte_b = burst_data[first + 1];
            end
            r.last   = (i == n_res - 1);
            r.status = r.last ? st : STAT_OK;
            due_results.push_back(r);
        end
    endfunction

    function automatic int draw_wait(input int side);
        if (quiet_left[side] > 0)
        begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            quiet_left[side] = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic void match_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            error_total++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Valid stays high from one item to the next unless a gap is drawn.
    task automatic offer_item(input logic f, input logic [VALUE_W-1:0] v);
        int gap;
        gap = draw_wait(SIDE_SEND);
        if (gap > 0)
        begin
            stream_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_ch.valid <= 1'b1;
        stream_ch.func  <= f;
        stream_ch.value <= v;
        do @(posedge clk); while (stream_ch.ready !== 1'b1);
        decode_byte(f, v);
        items_sent++;
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        stream_ch.valid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= m;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        img_mode = m;
    endtask

    task automatic send_run(input bit is_rep, input int len);
        int k;
        if (is_rep)
        begin
            offer_item(FUNC_DATA, VALUE_W'(REPEAT_BASE - len));
            offer_item(FUNC_DATA, VALUE_W'($urandom_range(0, 255)));
        end
        else
        begin
            offer_item(FUNC_DATA, VALUE_W'(len - 1));
            for (k = 0; k < len; k++)
                offer_item(FUNC_DATA, VALUE_W'($urandom_range(0, 255)));
        end
    endtask

    // Well-formed runs, mostly long repeats, writing exactly the given byte total.
    task automatic fill_bytes(input int total);
        int n;
        while (total > 0)
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                n = $urandom_range(1, 4);
                if (n > total)
                    n = total;
                send_run(1'b0, n);
            end
            else
            begin
                n = ($urandom_range(0, 15) != 0) ? 128 : $urandom_range(2, 128);
                if (n > total)
                    n = total;
                // A single byte left over has to go as a literal.
                send_run(n > 1, n);
            end
            total -= n;
        end
    endtask

    task automatic random_items(input int count);
        int start_at;
        int pick;
        int r;
        start_at = items_sent;
        while (items_sent - start_at < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                r = $urandom_range(0, 9);
                send_run(1'b1, (r == 0) ? 2 : (r == 1) ? 128 : $urandom_range(2, 128));
            end
            else if (pick < 65)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_run(1'b0, $urandom_range(21, 128));
                else
                    send_run(1'b0, $urandom_range(1, 4));
            end
            else if (pick < 72)
            begin
                offer_item(FUNC_DATA, PFX_NOP);
            end
            else if (pick < 77)
            begin
                offer_item(FUNC_START, VALUE_W'($urandom_range(0, 255)));
            end
            else
            begin
                offer_item(($urandom_range(0, 9) == 0) ? FUNC_START : FUNC_DATA,
                           VALUE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic dir_row(input logic f, input logic [VALUE_W-1:0] v, input logic typed,
                           input logic [COUNT_W-1:0] wc, input logic [ADDR_W-1:0] a,
                           input logic [VALUE_W-1:0] d, input logic [STAT_W-1:0] st);
        stim_row_t row;
        row = '{f, v, typed, wc, a, d, st};
        directed_rows.push_back(row);
    endtask

    // Result side: stalls drawn per item, plus one long hold-off to back up the input.
    initial
    begin
        int            stall;
        screen_write_t want;
        writes_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (results_taken == 2000)
                stall = 600;
            else
                stall = draw_wait(SIDE_RECV);
            if (stall > 0)
            begin
                writes_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            writes_ch.ready <= 1'b1;
            do @(posedge clk); while (writes_ch.valid !== 1'b1);
            results_taken++;
            if (due_results.size() == 0)
            begin
                error_total++;
                $display("%0t ns: result with nothing expected, write_count %0d status %0d",
                         $time, writes_ch.write_count, writes_ch.status);
            end
            else
            begin
                want = due_results.pop_front();
                match_field("write_count", want.write_count, writes_ch.write_count);
                match_field("addr_a", want.addr_a, writes_ch.addr_a);
                match_field("byte_a", want.byte_a, writes_ch.byte_a);
                match_field("addr_b", want.addr_b, writes_ch.addr_b);
                match_field("byte_b", want.byte_b, writes_ch.byte_b);
                match_field("last", want.last, writes_ch.last);
                match_field("status", want.status, writes_ch.status);
            end
        end
    end

    initial
    begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        stim_row_t     row;
        screen_write_t typed_res;
        int            i;
        error_total   = 0;
        items_sent    = 0;
        results_taken = 0;
        quiet_left    = '{0, 0};
        img_mode      = MODE_RESET;
        clear_position();
        rst_n           <= 1'b0;
        stream_ch.valid <= 1'b0;
        stream_ch.func  <= FUNC_DATA;
        stream_ch.value <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.data     <= MODE_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, in the mode left by reset. Prefixes and starts give one
        // empty result; the lone literal byte lands at offset zero.
        dir_row(FUNC_START, 8'hFF, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, PFX_NOP, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'h00, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'hFF, 1'b1, 2'd1, '0, 8'hFF, STAT_OK);
        dir_row(FUNC_DATA, 8'h01, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'h00, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_DATA, 8'h55, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_DATA, 8'hFF, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'hAA, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_DATA, REPEAT_MIN, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'h3C, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_DATA, 8'd130, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'h81, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_DATA, LITERAL_MAX, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'h7F, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_DATA, 8'h80, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_START, 8'h00, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'h03, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        dir_row(FUNC_DATA, 8'hC3, 1'b0, '0, '0, '0, STAT_OK);
        dir_row(FUNC_START, 8'h5A, 1'b1, 2'd0, '0, 8'h00, STAT_OK);
        for (i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            offer_item(row.func, row.value);
            if (row.typed)
            begin
                typed_res = '{row.write_count, row.addr, row.data, '0, '0, 1'b1, row.status};
                void'(due_results.pop_back());
                due_results.push_back(typed_res);
            end
        end

        // Half a screen in single-plane mode leaves the row count at 200, so the
        // switch to four planes makes the image complete; bytes after it overrun.
        write_mode(MODE_1PLANE);
        offer_item(FUNC_START, 8'h00);
        fill_bytes(16000);
        write_mode(MODE_4PLANE);
        offer_item(FUNC_DATA, PFX_NOP);
        send_run(1'b0, 1);
        send_run(1'b1, 5);
        offer_item(FUNC_START, 8'h00);

        // Random streams; the mode changes without a start between them.
        random_items(12);
        write_mode(MODE_2PLANE);
        random_items(12);
        write_mode(MODE_ALIAS);
        random_items(12);
        write_mode(MODE_1PLANE);
        random_items(12);

        stream_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_total == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
